// ----- design/lat_pkg.sv -----
// shared types and constants for the toroidal life automaton
package lat_pkg;

    // default grid geometry
    localparam int GRID_COLS_DEF = 64;
    localparam int PAIR_ROWS_DEF = 32;

    // payload field widths
    localparam int KIND_W      = 2;
    localparam int COL_FIELD_W = 6;
    localparam int ROW_FIELD_W = 6;
    localparam int SHADE_W     = 2;

    // beat packing
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = KIND_W;
    localparam int OUT_TDATA_W = 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * SHADE_W;

    // life rule neighbour counts
    localparam int NBR_W        = 4;
    localparam int BIRTH_COUNT  = 3;
    localparam int SURVIVE_LOW  = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_STEP  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    localparam logic [SHADE_W-1:0] SHADE_DEAD = 2'd0;
    localparam logic [SHADE_W-1:0] SHADE_WAS  = 2'd1;
    localparam logic [SHADE_W-1:0] SHADE_LIVE = 2'd2;

    // control shared by every row cell of the ring
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

endpackage

// ----- design/lat_row_cell.sv -----
// one row cell of the rotating ring: current and previous generation of a row
module lat_row_cell #(
    parameter int GRID_COLS = lat_pkg::GRID_COLS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lat_pkg::cell_ctl_t    ctl,
    input  logic [GRID_COLS-1:0]  in_now,
    input  logic [GRID_COLS-1:0]  in_before,
    output logic [GRID_COLS-1:0]  now_row,
    output logic [GRID_COLS-1:0]  before_row
);

    logic [GRID_COLS-1:0] now_reg;
    logic [GRID_COLS-1:0] before_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            now_reg    <= '0;
            before_reg <= '0;
        end else if (ctl.shift) begin
            now_reg    <= in_now;
            before_reg <= in_before;
        end
    end

    assign now_row    = now_reg;
    assign before_row = before_reg;

endmodule

// ----- design/lat_next_row.sv -----
// next generation of one row from the row above, itself and the row below
module lat_next_row #(
    parameter int GRID_COLS = lat_pkg::GRID_COLS_DEF
) (
    input  logic [GRID_COLS-1:0] up_row,
    input  logic [GRID_COLS-1:0] mid_row,
    input  logic [GRID_COLS-1:0] dn_row,
    output logic [GRID_COLS-1:0] fresh_row
);

    for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
        localparam int LF = (c + GRID_COLS - 1) % GRID_COLS;
        localparam int RT = (c + 1) % GRID_COLS;

        logic [lat_pkg::NBR_W-1:0] count;

        always_comb begin
            count = lat_pkg::NBR_W'(up_row[LF]) + lat_pkg::NBR_W'(up_row[c])
                  + lat_pkg::NBR_W'(up_row[RT]) + lat_pkg::NBR_W'(mid_row[LF])
                  + lat_pkg::NBR_W'(mid_row[RT]) + lat_pkg::NBR_W'(dn_row[LF])
                  + lat_pkg::NBR_W'(dn_row[c]) + lat_pkg::NBR_W'(dn_row[RT]);
            fresh_row[c] = (count == lat_pkg::NBR_W'(lat_pkg::BIRTH_COUNT))
                         || (mid_row[c] && count == lat_pkg::NBR_W'(lat_pkg::SURVIVE_LOW));
        end
    end

endmodule

// ----- design/life_automaton_torus.sv -----
// top level of the toroidal life automaton: row ring, sequencer and result register
//
//  channel | ports                          | beat contents (lowest bit first)
//  --------+--------------------------------+------------------------------------------
//  input   | s_tvalid s_tready s_tdata/tuser| tuser: kind[1:0]
//          |                                | tdata: col[5:0] row[11:6] alive[12], pad
//  result  | m_tvalid m_tready m_tdata      | tdata: shade_top[1:0] shade_bottom[3:2], pad
//
// - write, step and read beats turn the ring of row cells once, one row per cycle past the
//   single next-row unit, before the result register is loaded
// - a clear beat does not turn the ring: all cells are wiped at the accept edge and the
//   result register is loaded from the finish state
// - one beat in flight; the next is taken while the previous result waits on m_tready
// - synchronous active-low reset: both grids dead, no result pending
// - every accepted beat yields exactly one result beat, zero unless it is a read
module life_automaton_torus #(
    parameter int GRID_COLS = lat_pkg::GRID_COLS_DEF,
    parameter int PAIR_ROWS = lat_pkg::PAIR_ROWS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input beat
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lat_pkg::IN_TDATA_W-1:0]  s_tdata,   // col[5:0], row[11:6], alive[12]
    input  logic [lat_pkg::IN_TUSER_W-1:0]  s_tuser,   // kind[1:0]
    // result beat
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lat_pkg::OUT_TDATA_W-1:0] m_tdata    // shade_top[1:0], shade_bottom[3:2]
);

    localparam int GRID_ROWS = 2 * PAIR_ROWS;
    localparam int ROW_W     = $clog2(GRID_ROWS);
    localparam int COL_W     = $clog2(GRID_COLS);
    // common width for comparing the ring position with the row field
    localparam int CMP_W     = (ROW_W > lat_pkg::ROW_FIELD_W) ? ROW_W : lat_pkg::ROW_FIELD_W;
    localparam int COL_CMP_W = lat_pkg::COL_FIELD_W + 1;
    localparam logic [COL_CMP_W-1:0] COL_LIMIT = COL_CMP_W'(GRID_COLS);
    localparam logic [ROW_W-1:0]     LAST_POS  = ROW_W'(GRID_ROWS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    // ring of row cells; cell 0 is the head, rows move towards it
    logic [GRID_COLS-1:0] row_now    [GRID_ROWS];
    logic [GRID_COLS-1:0] row_before [GRID_ROWS];
    logic [GRID_COLS-1:0] tail_now;
    logic [GRID_COLS-1:0] tail_before;
    lat_pkg::cell_ctl_t   cell_ctl;

    // sequencer state
    state_t                              state_reg,  state_next;
    logic [ROW_W-1:0]                    pos_reg,    pos_next;
    lat_pkg::kind_t                      kind_reg,   kind_next;
    logic [lat_pkg::COL_FIELD_W-1:0]     col_reg,    col_next;
    logic [lat_pkg::ROW_FIELD_W-1:0]     row_reg,    row_next;
    logic                                alive_reg,  alive_next;
    // old contents of row 0 and of the row just retired, needed as neighbours
    logic [GRID_COLS-1:0]                first_old_reg, first_old_next;
    logic [GRID_COLS-1:0]                prev_old_reg,  prev_old_next;
    logic [lat_pkg::SHADE_W-1:0]         top_reg,    top_next;
    logic [lat_pkg::SHADE_W-1:0]         bottom_reg, bottom_next;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic [lat_pkg::OUT_TDATA_W-1:0]     m_tdata_reg,  m_tdata_next;

    logic                 s_accept;
    logic                 col_ok;
    logic [COL_W-1:0]     col_idx;
    logic [CMP_W-1:0]     pos_cmp;
    logic [CMP_W-1:0]     row_cmp;
    logic [CMP_W-1:0]     pair_cmp;
    logic                 write_hit;
    logic                 read_hit;
    logic [GRID_COLS-1:0] wr_mask;
    logic [GRID_COLS-1:0] head_written;
    logic [GRID_COLS-1:0] up_row;
    logic [GRID_COLS-1:0] dn_row;
    logic [GRID_COLS-1:0] fresh_row;

    function automatic logic [lat_pkg::SHADE_W-1:0] shade_of(input logic now_bit,
                                                             input logic before_bit);
        if (now_bit) begin
            return lat_pkg::SHADE_LIVE;
        end else if (before_bit) begin
            return lat_pkg::SHADE_WAS;
        end
        return lat_pkg::SHADE_DEAD;
    endfunction

    // the ring
    for (genvar k = 0; k < GRID_ROWS; k++) begin : g_cell
        if (k == GRID_ROWS - 1) begin : g_tail
            lat_row_cell #(.GRID_COLS(GRID_COLS)) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (cell_ctl),
                .in_now     (tail_now),
                .in_before  (tail_before),
                .now_row    (row_now[k]),
                .before_row (row_before[k])
            );
        end else begin : g_body
            lat_row_cell #(.GRID_COLS(GRID_COLS)) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (cell_ctl),
                .in_now     (row_now[k+1]),
                .in_before  (row_before[k+1]),
                .now_row    (row_now[k]),
                .before_row (row_before[k])
            );
        end
    end

    // next generation of the row at the head
    lat_next_row #(.GRID_COLS(GRID_COLS)) u_next_row (
        .up_row    (up_row),
        .mid_row   (row_now[0]),
        .dn_row    (dn_row),
        .fresh_row (fresh_row)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // head row neighbours: row above is retired already except on the first step,
    // row below is the old row 0 on the last step
    assign up_row = (pos_reg == '0) ? row_now[GRID_ROWS-1] : prev_old_reg;
    assign dn_row = (pos_reg == LAST_POS) ? first_old_reg : row_now[1];

    // addressing of the row passing the head
    assign col_ok   = {1'b0, col_reg} < COL_LIMIT;
    assign col_idx  = col_reg[COL_W-1:0];
    assign pos_cmp  = CMP_W'(pos_reg);
    assign row_cmp  = CMP_W'(row_reg);
    assign pair_cmp = {row_cmp[CMP_W-1:1], 1'b0};
    assign write_hit = (kind_reg == lat_pkg::KIND_WRITE) && col_ok && (pos_cmp == row_cmp);
    assign read_hit  = (kind_reg == lat_pkg::KIND_READ) && col_ok && (pos_cmp == pair_cmp);
    assign wr_mask   = col_ok ? (GRID_COLS'(1) << col_idx) : '0;
    assign head_written = alive_reg ? (row_now[0] | wr_mask) : (row_now[0] & ~wr_mask);

    // what leaves the head re-enters at the tail
    always_comb begin
        if (kind_reg == lat_pkg::KIND_STEP) begin
            tail_now    = fresh_row;
            tail_before = row_now[0];
        end else if (write_hit) begin
            tail_now    = head_written;
            tail_before = row_before[0];
        end else begin
            tail_now    = row_now[0];
            tail_before = row_before[0];
        end
    end

    always_comb begin
        cell_ctl.shift = (state_reg == ST_RUN);
        cell_ctl.clear = s_accept && (lat_pkg::kind_t'(s_tuser[lat_pkg::KIND_W-1:0])
                                      == lat_pkg::KIND_CLEAR);
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        kind_next      = kind_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        alive_next     = alive_reg;
        first_old_next = first_old_reg;
        prev_old_next  = prev_old_reg;
        top_next       = top_reg;
        bottom_next    = bottom_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    kind_next   = lat_pkg::kind_t'(s_tuser[lat_pkg::KIND_W-1:0]);
                    col_next    = s_tdata[lat_pkg::COL_FIELD_W-1:0];
                    row_next    = s_tdata[lat_pkg::COL_FIELD_W +: lat_pkg::ROW_FIELD_W];
                    alive_next  = s_tdata[lat_pkg::COL_FIELD_W + lat_pkg::ROW_FIELD_W];
                    top_next    = lat_pkg::SHADE_DEAD;
                    bottom_next = lat_pkg::SHADE_DEAD;
                    pos_next    = '0;
                    if (kind_next == lat_pkg::KIND_CLEAR) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                prev_old_next = row_now[0];
                if (pos_reg == '0) begin
                    first_old_next = row_now[0];
                end
                if (read_hit) begin
                    top_next    = shade_of(row_now[0][col_idx], row_before[0][col_idx]);
                    bottom_next = shade_of(row_now[1][col_idx], row_before[1][col_idx]);
                end
                pos_next = pos_reg + 1'b1;
                if (pos_reg == LAST_POS) begin
                    pos_next   = '0;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{lat_pkg::OUT_PAD_W{1'b0}}, bottom_reg, top_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        kind_reg      <= kind_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        alive_reg     <= alive_next;
        first_old_reg <= first_old_next;
        prev_old_reg  <= prev_old_next;
        top_reg       <= top_next;
        bottom_reg    <= bottom_next;
        m_tdata_reg   <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // the ring turns a full lap before the result is formed
    a_full_lap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && pos_reg != LAST_POS) |=> (state_reg == ST_RUN))
        else $error("ring left the sweep before a full lap");

    // a new result only ever comes out of the finish state
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !$past(m_tvalid_reg && !m_tready)) |-> $past(state_reg == ST_FINISH))
        else $error("result loaded outside the finish state");

    // non-read items give zero shades
    a_zero_shade: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && kind_reg != lat_pkg::KIND_READ)
            |-> (top_reg == lat_pkg::SHADE_DEAD && bottom_reg == lat_pkg::SHADE_DEAD))
        else $error("shade captured on a non-read item");

    // a clear wipes the ring at once
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_ctl.clear |=> (row_now[0] == '0 && row_before[GRID_ROWS-1] == '0))
        else $error("grids not cleared");

endmodule

// ----- tb/life_shade_checker.sv -----
// watches both channels of the life automaton, predicts every result beat and compares
module life_shade_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [lat_pkg::IN_TDATA_W-1:0]  s_tdata,   // col[5:0], row[11:6], alive[12]
    input  logic [lat_pkg::IN_TUSER_W-1:0]  s_tuser,   // kind[1:0]
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [lat_pkg::OUT_TDATA_W-1:0] m_tdata,   // shade_top[1:0], shade_bottom[3:2]
    output int                              fail_count,
    output int                              pending_count
);

    localparam int COLS = lat_pkg::GRID_COLS_DEF;
    localparam int ROWS = 2 * lat_pkg::PAIR_ROWS_DEF;

    typedef struct packed {
        logic [lat_pkg::SHADE_W-1:0] top;
        logic [lat_pkg::SHADE_W-1:0] bottom;
    } shade_pair_t;

    logic [COLS-1:0] cells_now  [ROWS];
    logic [COLS-1:0] cells_prev [ROWS];
    shade_pair_t     shade_fifo [$];

    lat_pkg::kind_t  in_kind;
    int              in_col;
    int              in_row;
    logic            in_alive;
    shade_pair_t     want;
    shade_pair_t     got;

    function automatic logic [lat_pkg::SHADE_W-1:0] shade_at(int c, int r);
        if (c >= COLS || r >= ROWS)
            return lat_pkg::SHADE_DEAD;
        if (cells_now[r][c])
            return lat_pkg::SHADE_LIVE;
        if (cells_prev[r][c])
            return lat_pkg::SHADE_WAS;
        return lat_pkg::SHADE_DEAD;
    endfunction

    function automatic void next_generation();
        logic [COLS-1:0] fresh [ROWS];
        int n;
        int up;
        int dn;
        int lf;
        int rt;
        for (int r = 0; r < ROWS; r++) begin
            up = (r + ROWS - 1) % ROWS;
            dn = (r + 1) % ROWS;
            fresh[r] = '0;
            for (int c = 0; c < COLS; c++) begin
                lf = (c + COLS - 1) % COLS;
                rt = (c + 1) % COLS;
                n = cells_now[up][lf] + cells_now[up][c] + cells_now[up][rt]
                  + cells_now[r][lf] + cells_now[r][rt]
                  + cells_now[dn][lf] + cells_now[dn][c] + cells_now[dn][rt];
                if (cells_now[r][c])
                    fresh[r][c] = (n == lat_pkg::SURVIVE_LOW) || (n == lat_pkg::BIRTH_COUNT);
                else
                    fresh[r][c] = (n == lat_pkg::BIRTH_COUNT);
            end
        end
        cells_prev = cells_now;
        cells_now  = fresh;
    endfunction

    function automatic void wipe_grids();
        for (int r = 0; r < ROWS; r++) begin
            cells_now[r]  = '0;
            cells_prev[r] = '0;
        end
    endfunction

    initial begin
        fail_count    = 0;
        pending_count = 0;
        wipe_grids();
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                in_kind  = lat_pkg::kind_t'(s_tuser);
                in_col   = int'(s_tdata[5:0]);
                in_row   = int'(s_tdata[11:6]);
                in_alive = s_tdata[12];
                want     = '0;
                case (in_kind)
                    lat_pkg::KIND_WRITE: begin
                        if (in_col < COLS && in_row < ROWS)
                            cells_now[in_row][in_col] = in_alive;
                    end
                    lat_pkg::KIND_STEP: begin
                        next_generation();
                    end
                    lat_pkg::KIND_READ: begin
                        if (in_col < COLS && (in_row / 2) < lat_pkg::PAIR_ROWS_DEF) begin
                            want.top    = shade_at(in_col, 2 * (in_row / 2));
                            want.bottom = shade_at(in_col, 2 * (in_row / 2) + 1);
                        end
                    end
                    default: begin
                        wipe_grids();
                    end
                endcase
                shade_fifo.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.top    = m_tdata[1:0];
                got.bottom = m_tdata[3:2];
                if (shade_fifo.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result beat: top %0d bottom %0d",
                                 got.top, got.bottom);
                    fail_count++;
                end else begin
                    want = shade_fifo.pop_front();
                    if (got.top !== want.top || got.bottom !== want.bottom) begin
                        if (fail_count < 10)
                            $display("shade mismatch: expected %0d/%0d, got %0d/%0d",
                                     want.top, want.bottom, got.top, got.bottom);
                        fail_count++;
                    end
                end
            end
            pending_count = shade_fifo.size();
        end
    end

endmodule

// ----- tb/life_automaton_torus_tb.sv -----
// stimulus and verdict for the toroidal life automaton, checking done beside it
module life_automaton_torus_tb;

    localparam int BEAT_TARGET  = 1650;
    localparam int CYCLE_LIMIT  = 1000000;
    // one beat turns the row ring once, plus a little slack
    localparam int DRAIN_CYCLES = 2 * lat_pkg::PAIR_ROWS_DEF + 2 + 20;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [lat_pkg::IN_TDATA_W-1:0]    s_tdata;   // col[5:0], row[11:6], alive[12]
    logic [lat_pkg::IN_TUSER_W-1:0]    s_tuser;   // kind[1:0]
    logic                              m_tvalid;
    logic                              m_tready;
    logic [lat_pkg::OUT_TDATA_W-1:0]   m_tdata;   // shade_top[1:0], shade_bottom[3:2]

    int                       fail_count;
    int                       pending_count;

    int                       beats_sent;
    bit                       sender_burst;   // no gaps while set
    bit                       paused_once;

    life_automaton_torus dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    life_shade_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // 10 unit period
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog: far above the slowest legal run
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("life_automaton_torus verification failed");
        $finish;
    end

    // wait at falling edges until every predicted beat has come back
    task automatic wait_drained();
        @(negedge aclk);
        while (pending_count != 0)
            @(negedge aclk);
    endtask

    // offer one input beat after a random gap, hold it until accepted
    task automatic send_beat(lat_pkg::kind_t k, int c, int r, bit a);
        int gap;
        logic [lat_pkg::IN_TDATA_W-1:0] word;
        gap  = sender_burst ? 0 : $urandom_range(0, 6);
        word = '0;
        word[5:0]  = c[5:0];
        word[11:6] = r[5:0];
        word[12]   = a;
        if (gap != 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
        // sender pause: let the block run dry once, mid-run
        if (!paused_once && beats_sent >= 900) begin
            paused_once = 1'b1;
            @(negedge aclk);
            s_tvalid <= 1'b0;
            while (pending_count != 0)
                @(negedge aclk);
        end
    endtask

    // cell near a focus point, wrapping round the torus
    function automatic int near(int centre, int spread);
        return (centre + 64 + $urandom_range(0, 2 * spread) - spread) % 64;
    endfunction

    // focus point, often hugging an edge so the wrap gets exercised
    function automatic int pick_focus();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 2);
            1:       return $urandom_range(61, 63);
            default: return $urandom_range(0, 63);
        endcase
    endfunction

    // result side: random stall per beat, one long hold-off to back the block up
    initial begin
        int stall;
        int beats_taken;
        int calm_left;
        m_tready    <= 1'b0;
        beats_taken = 0;
        calm_left   = 0;
        @(posedge aresetn);
        forever begin
            if (beats_taken == 300)
                stall = 500;
            else if (calm_left > 0) begin
                stall = 0;
                calm_left--;
            end else begin
                stall = $urandom_range(0, 6);
                if ($urandom_range(0, 19) == 0)
                    calm_left = $urandom_range(10, 40);
            end
            if (stall != 0) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
                @(negedge aclk);
                m_tready <= 1'b1;
            end else if (!m_tready) begin
                @(negedge aclk);
                m_tready <= 1'b1;
            end
            do @(posedge aclk); while (!m_tvalid);
            beats_taken++;
        end
    end

    // stimulus and verdict
    initial begin
        int fc;
        int fr;
        int cells;
        int gens;
        int reads;
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= lat_pkg::KIND_WRITE;
        beats_sent   = 0;
        sender_burst = 1'b0;
        paused_once  = 1'b0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty grid, corner block straddling both wraps
        send_beat(lat_pkg::KIND_READ, 0, 0, 1'b0);
        send_beat(lat_pkg::KIND_WRITE, 0, 0, 1'b1);
        send_beat(lat_pkg::KIND_WRITE, 63, 0, 1'b1);
        send_beat(lat_pkg::KIND_WRITE, 0, 63, 1'b1);
        send_beat(lat_pkg::KIND_WRITE, 63, 63, 1'b1);
        send_beat(lat_pkg::KIND_READ, 0, 1, 1'b0);
        send_beat(lat_pkg::KIND_READ, 63, 62, 1'b0);
        send_beat(lat_pkg::KIND_STEP, 0, 0, 1'b0);
        send_beat(lat_pkg::KIND_READ, 63, 0, 1'b0);
        send_beat(lat_pkg::KIND_READ, 0, 63, 1'b0);
        // write touches only the current grid
        send_beat(lat_pkg::KIND_WRITE, 0, 0, 1'b0);
        send_beat(lat_pkg::KIND_READ, 0, 0, 1'b1);
        send_beat(lat_pkg::KIND_STEP, 63, 63, 1'b1);
        send_beat(lat_pkg::KIND_READ, 0, 0, 1'b0);
        send_beat(lat_pkg::KIND_READ, 63, 63, 1'b0);
        // blinker mid-grid, flips between row and column
        send_beat(lat_pkg::KIND_CLEAR, 0, 0, 1'b0);
        send_beat(lat_pkg::KIND_WRITE, 31, 32, 1'b1);
        send_beat(lat_pkg::KIND_WRITE, 32, 32, 1'b1);
        send_beat(lat_pkg::KIND_WRITE, 33, 32, 1'b1);
        send_beat(lat_pkg::KIND_STEP, 0, 0, 1'b0);
        send_beat(lat_pkg::KIND_READ, 32, 33, 1'b0);
        send_beat(lat_pkg::KIND_READ, 31, 32, 1'b0);
        // clear wipes both generations
        send_beat(lat_pkg::KIND_CLEAR, 63, 63, 1'b1);
        send_beat(lat_pkg::KIND_READ, 32, 32, 1'b0);

        // random: mostly seeded patterns that are stepped and read back
        while (beats_sent < BEAT_TARGET) begin
            sender_burst = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 6) != 0) begin
                if ($urandom_range(0, 1) == 0)
                    send_beat(lat_pkg::KIND_CLEAR, $urandom_range(0, 63),
                              $urandom_range(0, 63), 1'($urandom_range(0, 1)));
                fc    = pick_focus();
                fr    = pick_focus();
                cells = $urandom_range(6, 20);
                repeat (cells)
                    send_beat(lat_pkg::KIND_WRITE, near(fc, 3), near(fr, 3),
                              ($urandom_range(0, 4) != 0));
                gens = $urandom_range(1, 4);
                repeat (gens) begin
                    send_beat(lat_pkg::KIND_STEP, $urandom_range(0, 63),
                              $urandom_range(0, 63), 1'($urandom_range(0, 1)));
                    reads = $urandom_range(3, 8);
                    repeat (reads)
                        send_beat(lat_pkg::KIND_READ, near(fc, 4), near(fr, 4),
                                  1'($urandom_range(0, 1)));
                end
            end else begin
                // noise: any kind, anywhere
                repeat (5)
                    send_beat(lat_pkg::kind_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                              $urandom_range(0, 63), 1'($urandom_range(0, 1)));
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("life_automaton_torus verification clean");
        else
            $display("life_automaton_torus verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
design/lat_pkg.sv
design/lat_row_cell.sv
design/lat_next_row.sv
design/life_automaton_torus.sv
tb/life_shade_checker.sv
tb/life_automaton_torus_tb.sv
